/* src/ssm_pkg.sv */
// shared types, constants and character functions for the seven-segment mux
`timescale 1ns / 1ps

package ssm_pkg;

   localparam int unsigned BLINK_LIMIT_DEFAULT = 10;
   localparam int unsigned NUM_DIGITS = 6;
   localparam int unsigned DIGITS_PER_DISPLAY = 3;

   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] FONT_FIRST = 8'h30;

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_WRITE_NUMBER = 2'd1,
      OP_WRITE_TEXT   = 2'd2,
      OP_SET_BLINK    = 2'd3
   } op_type;

   typedef logic [7:0] char_type;

   typedef struct packed {
      op_type     op;
      logic       display_sel;
      logic [9:0] number_value;
      char_type   char_first;
      char_type   char_second;
      char_type   char_third;
      logic       blink_on;
   } req_type;

   typedef struct packed {
      logic [6:0] segment_lines;
      logic [5:0] digit_lines;
   } rsp_type;

   typedef struct packed {
      char_type hundreds;
      char_type tens;
      char_type ones;
   } dec_type;

   // low three decimal digits as character codes
   function automatic dec_type to_decimal(logic [9:0] value);
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] o;
      logic [3:0] hd;
      logic [9:0] rem_wide;
      logic [6:0] rem;
      logic [6:0] rem_ones;
      dec_type    res;
      h = 4'd0;
      rem_wide = value;
      for (int k = 1; k <= 10; k++) begin
         if (value >= 10'(k * 100)) begin
            h = 4'(k);
            rem_wide = value - 10'(k * 100);
         end
      end
      rem = rem_wide[6:0];
      t = 4'd0;
      rem_ones = rem;
      for (int k = 1; k <= 9; k++) begin
         if (rem >= 7'(k * 10)) begin
            t = 4'(k);
            rem_ones = rem - 7'(k * 10);
         end
      end
      o = rem_ones[3:0];
      hd = (h == 4'd10) ? 4'd0 : h;
      res.hundreds = FONT_FIRST + {4'd0, hd};
      res.tens = FONT_FIRST + {4'd0, t};
      res.ones = FONT_FIRST + {4'd0, o};
      return res;
   endfunction

   // segment pattern, a to g in bits 0 to 6; codes outside the font are blank
   function automatic logic [6:0] glyph(char_type code);
      logic [6:0] seg;
      case (code)
         8'h30: seg = 7'h3F;
         8'h31: seg = 7'h06;
         8'h32: seg = 7'h5B;
         8'h33: seg = 7'h4F;
         8'h34: seg = 7'h66;
         8'h35: seg = 7'h6D;
         8'h36: seg = 7'h7D;
         8'h37: seg = 7'h07;
         8'h38: seg = 7'h7F;
         8'h39: seg = 7'h6F;
         8'h3C: seg = 7'h61;
         8'h3D: seg = 7'h48;
         8'h3E: seg = 7'h4C;
         8'h3F: seg = 7'h53;
         8'h41: seg = 7'h77;
         8'h42: seg = 7'h7C;
         8'h43: seg = 7'h58;
         8'h44: seg = 7'h5E;
         8'h45: seg = 7'h79;
         8'h46: seg = 7'h71;
         8'h47: seg = 7'h6F;
         8'h48: seg = 7'h74;
         8'h49: seg = 7'h04;
         8'h4A: seg = 7'h0F;
         8'h4B: seg = 7'h68;
         8'h4C: seg = 7'h38;
         8'h4D: seg = 7'h37;
         8'h4E: seg = 7'h54;
         8'h4F: seg = 7'h5C;
         8'h50: seg = 7'h73;
         8'h51: seg = 7'h67;
         8'h52: seg = 7'h50;
         8'h53: seg = 7'h6D;
         8'h54: seg = 7'h78;
         8'h55: seg = 7'h1C;
         8'h56: seg = 7'h18;
         8'h57: seg = 7'h7E;
         8'h58: seg = 7'h76;
         8'h59: seg = 7'h6E;
         8'h5A: seg = 7'h5B;
         8'h5B: seg = 7'h52;
         8'h5D: seg = 7'h64;
         8'h5E: seg = 7'h01;
         8'h5F: seg = 7'h08;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

/* src/seven_segment_mux_with_blink.sv */
// top level: six-digit multiplexed seven-segment driver with per-display blinking
//
//   channel  ports                              direction  word
//   req      req_valid req_ready req_data       in         ssm_pkg::req_type
//   rsp      rsp_valid rsp_ready rsp_data       out        ssm_pkg::rsp_type, one per tick
//   csr      csr_valid csr_ready csr_data       in         common_anode bit
//
// one word per cycle unless a tick word waits on the rsp side; a word is held in
// the input register and a tick word's result then sits in the output register
// write and blink words produce no result and never wait on the rsp side
// a tick word waits in the input register while the output register is full
// synchronous reset loads spaces into all digits and clears scan, blink and frame state
`timescale 1ns / 1ps

module seven_segment_mux_with_blink #(
   parameter int unsigned BLINK_LIMIT = ssm_pkg::BLINK_LIMIT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int unsigned FRAME_W = $clog2(BLINK_LIMIT + 1);
   localparam int unsigned NUM_DIGITS = ssm_pkg::NUM_DIGITS;
   localparam logic [2:0] LAST_POS = 3'(NUM_DIGITS - 1);
   localparam logic [2:0] SECOND_BASE = 3'(ssm_pkg::DIGITS_PER_DISPLAY);

   logic                      req_valid_ff, req_valid_in;
   ssm_pkg::req_type          req_ff, req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ssm_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      common_anode_ff, common_anode_in;
   ssm_pkg::char_type         char_store_ff [NUM_DIGITS];
   ssm_pkg::char_type         char_store_in [NUM_DIGITS];
   logic [2:0]                scan_ff, scan_in;
   logic [1:0]                blink_en_ff, blink_en_in;
   logic                      phase_ff, phase_in;
   logic [FRAME_W-1:0]        frame_ff, frame_in;

   logic                      rsp_free;
   logic                      stage_go;
   logic [2:0]                base;
   logic [2:0]                pos;
   logic                      which;
   logic                      blank;
   logic [6:0]                seg;
   logic [5:0]                dig;
   ssm_pkg::dec_type          dec;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      rsp_free = !rsp_valid_ff || rsp_ready;
      stage_go = req_valid_ff && ((req_ff.op != ssm_pkg::OP_TICK) || rsp_free);
      req_ready = !req_valid_ff || stage_go;

      req_in = req_ff;
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_in = req_data;
         req_valid_in = 1'b1;
      end else if (stage_go) begin
         req_valid_in = 1'b0;
      end

      common_anode_in = csr_valid ? csr_data : common_anode_ff;

      char_store_in = char_store_ff;
      scan_in = scan_ff;
      blink_en_in = blink_en_ff;
      phase_in = phase_ff;
      frame_in = frame_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      base = req_ff.display_sel ? SECOND_BASE : 3'd0;
      dec = ssm_pkg::to_decimal(req_ff.number_value);

      // tick datapath
      pos = (scan_ff > LAST_POS) ? 3'd0 : scan_ff;
      which = (pos >= SECOND_BASE);
      blank = blink_en_ff[which] && phase_ff;
      seg = blank ? 7'd0 : ssm_pkg::glyph(char_store_ff[pos]);
      dig = blank ? 6'd0 : (6'b1 << pos);

      if (stage_go) begin
         unique case (req_ff.op)
            ssm_pkg::OP_WRITE_NUMBER: begin
               char_store_in[base] = dec.hundreds;
               char_store_in[3'(base + 3'd1)] = dec.tens;
               char_store_in[3'(base + 3'd2)] = dec.ones;
            end
            ssm_pkg::OP_WRITE_TEXT: begin
               char_store_in[base] = req_ff.char_first;
               char_store_in[3'(base + 3'd1)] = req_ff.char_second;
               char_store_in[3'(base + 3'd2)] = req_ff.char_third;
            end
            ssm_pkg::OP_SET_BLINK: begin
               blink_en_in[req_ff.display_sel] = req_ff.blink_on;
            end
            ssm_pkg::OP_TICK: begin
               rsp_valid_in = 1'b1;
               if (common_anode_ff) begin
                  rsp_in.segment_lines = ~seg;
                  rsp_in.digit_lines = dig;
               end else begin
                  rsp_in.segment_lines = seg;
                  rsp_in.digit_lines = ~dig;
               end
               // end of frame
               if (pos == LAST_POS) begin
                  scan_in = 3'd0;
                  if (frame_ff == FRAME_W'(BLINK_LIMIT)) begin
                     frame_in = '0;
                     phase_in = !phase_ff;
                  end else begin
                     frame_in = frame_ff + FRAME_W'(1);
                  end
               end else begin
                  scan_in = pos + 3'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         common_anode_ff <= 1'b0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            char_store_ff[i] <= ssm_pkg::SPACE_CODE;
         end
         scan_ff <= 3'd0;
         blink_en_ff <= 2'd0;
         phase_ff <= 1'b0;
         frame_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         common_anode_ff <= common_anode_in;
         char_store_ff <= char_store_in;
         scan_ff <= scan_in;
         blink_en_ff <= blink_en_in;
         phase_ff <= phase_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // scan never leaves the six digits
   assert property (@(posedge clock) disable iff (reset) scan_ff <= LAST_POS)
      else $error("scan position out of range");

   // frame counter stays within the blink period
   assert property (@(posedge clock) disable iff (reset) frame_ff <= FRAME_W'(BLINK_LIMIT))
      else $error("frame counter out of range");

   // at most one digit enabled in any result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($onehot0(rsp_ff.digit_lines) || $onehot0(~rsp_ff.digit_lines)))
      else $error("more than one digit enabled");

   // blink phase only flips at the end of a blink period
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (phase_ff != $past(phase_ff)))
         |-> ($past(frame_ff) == FRAME_W'(BLINK_LIMIT) && $past(scan_ff) == LAST_POS))
      else $error("blink phase changed mid period");

endmodule
